@@ src/sks_pkg.sv @@
`default_nettype none

package sks_pkg;

    localparam int KEY_W    = 32;
    localparam int POS_W    = 6;
    localparam int CNT_W    = POS_W + 1;
    localparam int CFG_IDX_W = 8;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DESCENDING_ORDER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_NEEDS_VALID  = 8'd1;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        pos;
    } t_rec;

    typedef struct packed {
        logic load;
        logic sort;
        logic shift;
        logic desc;
        logic odd;
        t_cnt count;
    } t_ctl;

endpackage

`default_nettype wire

@@ src/sks_cell.sv @@
`default_nettype none

module sks_cell #(
    parameter int IDX = 0
) (
    input  wire logic                     i_clk,
    input  wire sks_pkg::t_ctl            i_ctl,
    input  wire logic signed [31:0]       i_key,
    input  wire sks_pkg::t_rec            i_left,
    input  wire logic                     i_left_gt,
    input  wire sks_pkg::t_rec            i_right,
    output sks_pkg::t_rec                 o_rec,
    output logic                          o_gt
);
    import sks_pkg::*;

    localparam logic PAR      = 1'(IDX % 2);
    localparam logic HAS_LEFT = (IDX > 0);

    t_rec r_rec;
    t_rec n_rec;
    logic w_right_act;
    logic w_left_act;

    assign o_rec = r_rec;
    assign o_gt  = i_ctl.desc ? (r_rec.key < i_right.key) : (r_rec.key > i_right.key);

    assign w_right_act = i_ctl.sort && (PAR == i_ctl.odd) && (t_cnt'(IDX + 1) < i_ctl.count);
    assign w_left_act  = i_ctl.sort && HAS_LEFT && (PAR != i_ctl.odd)
                         && (t_cnt'(IDX) < i_ctl.count);

    always_comb begin
        n_rec = r_rec;
        if (i_ctl.load && (i_ctl.count == t_cnt'(IDX))) begin
            n_rec.key = i_key;
            n_rec.pos = POS_W'(IDX);
        end else if (i_ctl.shift) begin
            n_rec = i_right;
        end else if (w_right_act && o_gt) begin
            n_rec = i_right;
        end else if (w_left_act && i_left_gt) begin
            n_rec = i_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

`default_nettype wire

@@ src/sks_ctrl.sv @@
`default_nettype none

module sks_ctrl #(
    parameter int MAX_RECORDS = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_fire,
    input  wire logic                             i_valid,
    input  wire logic                             i_last,
    input  wire logic                             i_out_fire,
    input  wire logic                             i_cfg_fire,
    input  wire logic [sks_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic                             i_cfg_data,
    output sks_pkg::t_ctl                         o_ctl,
    output logic                                  o_in_ready,
    output logic                                  o_out_valid,
    output logic                                  o_reordered,
    output logic                                  o_truncated,
    output logic                                  o_last_out
);
    import sks_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_SORT = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    localparam t_cnt CAP = t_cnt'(MAX_RECORDS);

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    t_cnt   r_phase, n_phase;
    logic   r_all_valid, n_all_valid;
    logic   r_ovf, n_ovf;
    logic   r_reordered, n_reordered;
    logic   r_truncated, n_truncated;
    logic   r_desc, r_knv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc <= 1'b0;
            r_knv  <= 1'b0;
        end else if (i_cfg_fire) begin
            unique case (i_cfg_index)
                REG_DESCENDING_ORDER: r_desc <= i_cfg_data;
                REG_KEY_NEEDS_VALID:  r_knv  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic av;
        logic ov;
        n_state     = r_state;
        n_count     = r_count;
        n_phase     = r_phase;
        n_all_valid = r_all_valid;
        n_ovf       = r_ovf;
        n_reordered = r_reordered;
        n_truncated = r_truncated;
        av = r_all_valid;
        ov = r_ovf;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_fire) begin
                    if (r_count < CAP) begin
                        n_count = r_count + t_cnt'(1);
                        av = r_all_valid && i_valid;
                    end else begin
                        ov = 1'b1;
                    end
                    n_all_valid = av;
                    n_ovf       = ov;
                    if (i_last) begin
                        n_reordered = !(r_knv && !av);
                        n_truncated = ov;
                        n_phase     = '0;
                        n_state     = (r_knv && !av) ? S_OUT : S_SORT;
                    end
                end
            end
            S_SORT: begin
                n_phase = r_phase + t_cnt'(1);
                if (r_phase == r_count - t_cnt'(1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_fire) begin
                    n_count = r_count - t_cnt'(1);
                    if (r_count == t_cnt'(1)) begin
                        n_all_valid = 1'b1;
                        n_ovf       = 1'b0;
                        n_state     = S_LOAD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_phase     <= '0;
            r_all_valid <= 1'b1;
            r_ovf       <= 1'b0;
            r_reordered <= 1'b0;
            r_truncated <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_phase     <= n_phase;
            r_all_valid <= n_all_valid;
            r_ovf       <= n_ovf;
            r_reordered <= n_reordered;
            r_truncated <= n_truncated;
        end
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_OUT);
    assign o_reordered = r_reordered;
    assign o_truncated = r_truncated;
    assign o_last_out  = (r_count == t_cnt'(1));

    assign o_ctl.load  = (r_state == S_LOAD) && i_in_fire;
    assign o_ctl.sort  = (r_state == S_SORT);
    assign o_ctl.shift = (r_state == S_OUT) && i_out_fire;
    assign o_ctl.desc  = r_desc;
    assign o_ctl.odd   = r_phase[0];
    assign o_ctl.count = r_count;

endmodule

`default_nettype wire

@@ src/stable_key_sort_with_validity_gate_top.sv @@
`default_nettype none

// Channel  | Direction | Handshake                        | Payload
// s_axis   | in        | i_s_axis_tvalid / o_s_axis_tready | tdata key, tuser valid, tlast
// m_axis   | out       | o_m_axis_tvalid / i_m_axis_tready | tdata pos+key, tuser flags, tlast
// cfg      | in        | i_cfg_valid / o_cfg_ready         | i_cfg_index, i_cfg_data
//
// Loading writes each record into the next cell of a row of MAX_RECORDS cells.
// After the last record, odd-even transposition runs across the cell row,
// skipped when the validity gate forces arrival order.
// Results then shift out of cell 0, one per cycle while i_m_axis_tready is high.
// Synchronous active-low reset clears control state; cell contents are not reset.
// Input is not taken while a list is sorting or emitting; a stalled output holds.

module stable_key_sort_with_validity_gate_top #(
    parameter int MAX_RECORDS = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    input  wire logic [sks_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,  // [31:0] sort_key
    input  wire logic                                i_s_axis_tuser,  // [0] record_valid
    input  wire logic                                i_s_axis_tlast,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    output logic [sks_pkg::OUT_DATA_W-1:0]           o_m_axis_tdata,  // [5:0] position, [37:6] key
    output logic [sks_pkg::OUT_USER_W-1:0]           o_m_axis_tuser,  // [0] reordered, [1] truncated
    output logic                                     o_m_axis_tlast,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [sks_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic                                i_cfg_data
);
    import sks_pkg::*;

    t_ctl w_ctl;
    t_rec w_rec   [MAX_RECORDS];
    t_rec w_left  [MAX_RECORDS];
    t_rec w_right [MAX_RECORDS];
    logic w_gt    [MAX_RECORDS];
    logic w_lgt   [MAX_RECORDS];
    logic w_in_fire;
    logic w_out_fire;
    logic w_reordered;
    logic w_truncated;

    assign o_cfg_ready = 1'b1;
    assign w_in_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_fire  = o_m_axis_tvalid && i_m_axis_tready;

    sks_ctrl #(
        .MAX_RECORDS(MAX_RECORDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (w_in_fire),
        .i_valid     (i_s_axis_tuser),
        .i_last      (i_s_axis_tlast),
        .i_out_fire  (w_out_fire),
        .i_cfg_fire  (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ctl       (w_ctl),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_reordered (w_reordered),
        .o_truncated (w_truncated),
        .o_last_out  (o_m_axis_tlast)
    );

    for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign w_left[i] = '0;
            assign w_lgt[i]  = 1'b0;
        end else begin : g_mid
            assign w_left[i] = w_rec[i-1];
            assign w_lgt[i]  = w_gt[i-1];
        end
        if (i == MAX_RECORDS - 1) begin : g_end
            assign w_right[i] = '0;
        end else begin : g_nxt
            assign w_right[i] = w_rec[i+1];
        end

        sks_cell #(
            .IDX(i)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_key     (signed'(i_s_axis_tdata[KEY_W-1:0])),
            .i_left    (w_left[i]),
            .i_left_gt (w_lgt[i]),
            .i_right   (w_right[i]),
            .o_rec     (w_rec[i]),
            .o_gt      (w_gt[i])
        );
    end

    assign o_m_axis_tdata = {(OUT_DATA_W - KEY_W - POS_W)'(0), w_rec[0].key, w_rec[0].pos};
    assign o_m_axis_tuser = {w_truncated, w_reordered};

endmodule

`default_nettype wire

@@ src/sks_checker.sv @@
`default_nettype none

module sks_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_s_axis_tvalid,
    input wire logic                             o_s_axis_tready,
    input wire logic                             i_s_axis_tlast,
    input wire logic                             o_m_axis_tvalid,
    input wire logic                             i_m_axis_tready,
    input wire logic [sks_pkg::OUT_USER_W-1:0]   o_m_axis_tuser,
    input wire logic                             o_m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_no_load_during_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input ready while emitting a list");

    a_last_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=> !o_m_axis_tvalid)
        else $error("output valid after final transaction of a run");

    a_last_in_stops_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast) |=> !o_s_axis_tready)
        else $error("input ready right after final record");

    a_flags_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=> $stable(o_m_axis_tuser))
        else $error("run flags changed within a run");

endmodule

bind stable_key_sort_with_validity_gate_top sks_checker u_sks_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire
